/* sv/rv64d_pkg.sv */
// Shared types and constants for the RV64I instruction decoder.
// Holds opcode, funct and operation codes plus the decoded result struct.
// No dependencies; the decoder, top level and checker refer to it by scoped names, the testbench imports it.
`default_nettype none

package rv64d_pkg;

    // Major opcodes, bits 6:0
    localparam logic [6:0] OPC_LUI      = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC    = 7'b0010111;
    localparam logic [6:0] OPC_JAL      = 7'b1101111;
    localparam logic [6:0] OPC_JALR     = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH   = 7'b1100011;
    localparam logic [6:0] OPC_LOAD     = 7'b0000011;
    localparam logic [6:0] OPC_STORE    = 7'b0100011;
    localparam logic [6:0] OPC_OP_IMM   = 7'b0010011;
    localparam logic [6:0] OPC_OP_IMM32 = 7'b0011011;
    localparam logic [6:0] OPC_OP       = 7'b0110011;
    localparam logic [6:0] OPC_OP32     = 7'b0111011;
    localparam logic [6:0] OPC_MISC_MEM = 7'b0001111;
    localparam logic [6:0] OPC_SYSTEM   = 7'b1110011;

    // funct3 values that need special handling
    localparam logic [2:0] F3_ADD = 3'b000;
    localparam logic [2:0] F3_SLL = 3'b001;
    localparam logic [2:0] F3_SR  = 3'b101;

    // funct7 / funct6 qualifiers
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [5:0] F6_BASE = 6'b000000;
    localparam logic [5:0] F6_ALT  = 6'b010000;

    // System immediates
    localparam logic [11:0] IMM_ECALL  = 12'b000000000000;
    localparam logic [11:0] IMM_EBREAK = 12'b000000000001;
    localparam logic [11:0] IMM_SRET   = 12'b000100000010;
    localparam logic [11:0] IMM_MRET   = 12'b001100000010;

    typedef enum logic [2:0] {
        FMT_R = 3'd0,
        FMT_I = 3'd1,
        FMT_S = 3'd2,
        FMT_B = 3'd3,
        FMT_U = 3'd4,
        FMT_J = 3'd5
    } fmt_t;

    typedef enum logic [5:0] {
        OP_INVALID = 6'd0,
        OP_LUI   = 6'd1,  OP_AUIPC = 6'd2,  OP_JAL   = 6'd3,  OP_JALR  = 6'd4,
        OP_BEQ   = 6'd5,  OP_BNE   = 6'd6,  OP_BLT   = 6'd7,  OP_BGE   = 6'd8,
        OP_BLTU  = 6'd9,  OP_BGEU  = 6'd10, OP_LB    = 6'd11, OP_LH    = 6'd12,
        OP_LW    = 6'd13, OP_LBU   = 6'd14, OP_LHU   = 6'd15, OP_SB    = 6'd16,
        OP_SH    = 6'd17, OP_SW    = 6'd18, OP_ADDI  = 6'd19, OP_SLTI  = 6'd20,
        OP_SLTIU = 6'd21, OP_XORI  = 6'd22, OP_ORI   = 6'd23, OP_ANDI  = 6'd24,
        OP_SLLI  = 6'd25, OP_SRLI  = 6'd26, OP_SRAI  = 6'd27, OP_ADD   = 6'd28,
        OP_SUB   = 6'd29, OP_SLL   = 6'd30, OP_SLT   = 6'd31, OP_SLTU  = 6'd32,
        OP_XOR   = 6'd33, OP_SRL   = 6'd34, OP_SRA   = 6'd35, OP_OR    = 6'd36,
        OP_AND   = 6'd37, OP_FENCE = 6'd38, OP_ECALL = 6'd39, OP_EBREAK = 6'd40,
        OP_LWU   = 6'd41, OP_LD    = 6'd42, OP_SD    = 6'd43, OP_ADDIW = 6'd44,
        OP_SLLIW = 6'd45, OP_SRLIW = 6'd46, OP_SRAIW = 6'd47, OP_ADDW  = 6'd48,
        OP_SUBW  = 6'd49, OP_SLLW  = 6'd50, OP_SRLW  = 6'd51, OP_SRAW  = 6'd52,
        OP_SRET  = 6'd53, OP_MRET  = 6'd54
    } op_t;

    // funct3-indexed operation tables
    localparam op_t LOAD_OPS [8] = '{OP_LB, OP_LH, OP_LW, OP_LD,
                                     OP_LBU, OP_LHU, OP_LWU, OP_INVALID};
    localparam op_t STORE_OPS [8] = '{OP_SB, OP_SH, OP_SW, OP_SD,
                                      OP_INVALID, OP_INVALID, OP_INVALID, OP_INVALID};
    localparam op_t BRANCH_OPS [8] = '{OP_BEQ, OP_BNE, OP_INVALID, OP_INVALID,
                                       OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
    localparam op_t OPIMM_OPS [8] = '{OP_ADDI, OP_INVALID, OP_SLTI, OP_SLTIU,
                                      OP_XORI, OP_INVALID, OP_ORI, OP_ANDI};
    localparam op_t OP_BASE_OPS [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                        OP_XOR, OP_SRL, OP_OR, OP_AND};

    typedef struct packed {
        op_t         op;
        fmt_t        fmt;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } result_t;

endpackage

`default_nettype wire

/* sv/rv64d_instr_if.sv */
// Valid/ready channel carrying one raw instruction word per transaction.
// Standalone; used by the decoder top level as its input port.
`default_nettype none

interface rv64d_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

`default_nettype wire

/* sv/rv64d_decoded_if.sv */
// Valid/ready channel carrying one decoded instruction per transaction.
// Standalone; used by the decoder top level as its output port.
`default_nettype none

interface rv64d_decoded_if;
    logic        valid;
    logic        ready;
    logic [5:0]  operation_code;
    logic [2:0]  format_kind;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate_bits;

    modport source (output valid, output operation_code, output format_kind,
                    output dest_reg, output src1_reg, output src2_reg,
                    output immediate_bits, input ready);
    modport sink   (input valid, input operation_code, input format_kind,
                    input dest_reg, input src1_reg, input src2_reg,
                    input immediate_bits, output ready);
endinterface

`default_nettype wire

/* sv/rv64d_decode.sv */
// Combinational decode of one RV64I instruction word into a result struct.
// Depends on rv64d_pkg for opcodes, operation tables and result_t.
`default_nettype none

module rv64d_decode (
    input  wire logic [31:0]      word,
    output rv64d_pkg::result_t    res
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [11:0] imm_i;

    rv64d_pkg::op_t  op;
    rv64d_pkg::fmt_t fmt;

    assign opc   = word[6:0];
    assign f3    = word[14:12];
    assign f7    = word[31:25];
    assign f6    = word[31:26];
    assign rd    = word[11:7];
    assign rs1   = word[19:15];
    assign rs2   = word[24:20];
    assign imm_i = word[31:20];

    // Identify operation and encoding format
    always_comb
    begin
        op  = rv64d_pkg::OP_INVALID;
        fmt = rv64d_pkg::FMT_R;
        case (opc)
            rv64d_pkg::OPC_LUI:
            begin
                op  = rv64d_pkg::OP_LUI;
                fmt = rv64d_pkg::FMT_U;
            end
            rv64d_pkg::OPC_AUIPC:
            begin
                op  = rv64d_pkg::OP_AUIPC;
                fmt = rv64d_pkg::FMT_U;
            end
            rv64d_pkg::OPC_JAL:
            begin
                op  = rv64d_pkg::OP_JAL;
                fmt = rv64d_pkg::FMT_J;
            end
            rv64d_pkg::OPC_JALR:
            begin
                fmt = rv64d_pkg::FMT_I;
                if (f3 == rv64d_pkg::F3_ADD)
                    op = rv64d_pkg::OP_JALR;
            end
            rv64d_pkg::OPC_BRANCH:
            begin
                op  = rv64d_pkg::BRANCH_OPS[f3];
                fmt = rv64d_pkg::FMT_B;
            end
            rv64d_pkg::OPC_LOAD:
            begin
                op  = rv64d_pkg::LOAD_OPS[f3];
                fmt = rv64d_pkg::FMT_I;
            end
            rv64d_pkg::OPC_STORE:
            begin
                op  = rv64d_pkg::STORE_OPS[f3];
                fmt = rv64d_pkg::FMT_S;
            end
            rv64d_pkg::OPC_OP_IMM:
            begin
                fmt = rv64d_pkg::FMT_I;
                if (f3 == rv64d_pkg::F3_SLL)
                begin
                    if (f6 == rv64d_pkg::F6_BASE)
                        op = rv64d_pkg::OP_SLLI;
                end
                else if (f3 == rv64d_pkg::F3_SR)
                begin
                    if (f6 == rv64d_pkg::F6_BASE)
                        op = rv64d_pkg::OP_SRLI;
                    else if (f6 == rv64d_pkg::F6_ALT)
                        op = rv64d_pkg::OP_SRAI;
                end
                else
                begin
                    op = rv64d_pkg::OPIMM_OPS[f3];
                end
            end
            rv64d_pkg::OPC_OP_IMM32:
            begin
                fmt = rv64d_pkg::FMT_I;
                if (f3 == rv64d_pkg::F3_ADD)
                    op = rv64d_pkg::OP_ADDIW;
                else if (f3 == rv64d_pkg::F3_SLL && f7 == rv64d_pkg::F7_BASE)
                    op = rv64d_pkg::OP_SLLIW;
                else if (f3 == rv64d_pkg::F3_SR && f7 == rv64d_pkg::F7_BASE)
                    op = rv64d_pkg::OP_SRLIW;
                else if (f3 == rv64d_pkg::F3_SR && f7 == rv64d_pkg::F7_ALT)
                    op = rv64d_pkg::OP_SRAIW;
            end
            rv64d_pkg::OPC_OP:
            begin
                fmt = rv64d_pkg::FMT_R;
                if (f7 == rv64d_pkg::F7_BASE)
                    op = rv64d_pkg::OP_BASE_OPS[f3];
                else if (f7 == rv64d_pkg::F7_ALT && f3 == rv64d_pkg::F3_ADD)
                    op = rv64d_pkg::OP_SUB;
                else if (f7 == rv64d_pkg::F7_ALT && f3 == rv64d_pkg::F3_SR)
                    op = rv64d_pkg::OP_SRA;
            end
            rv64d_pkg::OPC_OP32:
            begin
                fmt = rv64d_pkg::FMT_R;
                if (f7 == rv64d_pkg::F7_BASE && f3 == rv64d_pkg::F3_ADD)
                    op = rv64d_pkg::OP_ADDW;
                else if (f7 == rv64d_pkg::F7_ALT && f3 == rv64d_pkg::F3_ADD)
                    op = rv64d_pkg::OP_SUBW;
                else if (f7 == rv64d_pkg::F7_BASE && f3 == rv64d_pkg::F3_SLL)
                    op = rv64d_pkg::OP_SLLW;
                else if (f7 == rv64d_pkg::F7_BASE && f3 == rv64d_pkg::F3_SR)
                    op = rv64d_pkg::OP_SRLW;
                else if (f7 == rv64d_pkg::F7_ALT && f3 == rv64d_pkg::F3_SR)
                    op = rv64d_pkg::OP_SRAW;
            end
            rv64d_pkg::OPC_MISC_MEM:
            begin
                fmt = rv64d_pkg::FMT_I;
                if (f3 == rv64d_pkg::F3_ADD)
                    op = rv64d_pkg::OP_FENCE;
            end
            rv64d_pkg::OPC_SYSTEM:
            begin
                fmt = rv64d_pkg::FMT_I;
                // Only the plain trap and return words; CSR forms stay invalid
                if (rd == 5'd0 && rs1 == 5'd0 && f3 == rv64d_pkg::F3_ADD)
                begin
                    case (imm_i)
                        rv64d_pkg::IMM_ECALL:  op = rv64d_pkg::OP_ECALL;
                        rv64d_pkg::IMM_EBREAK: op = rv64d_pkg::OP_EBREAK;
                        rv64d_pkg::IMM_SRET:   op = rv64d_pkg::OP_SRET;
                        rv64d_pkg::IMM_MRET:   op = rv64d_pkg::OP_MRET;
                        default:               op = rv64d_pkg::OP_INVALID;
                    endcase
                end
            end
            default:
            begin
                op  = rv64d_pkg::OP_INVALID;
                fmt = rv64d_pkg::FMT_R;
            end
        endcase
    end

    // Gate register fields and assemble the immediate per format
    always_comb
    begin
        res     = '0;
        res.op  = op;
        if (op != rv64d_pkg::OP_INVALID)
        begin
            res.fmt = fmt;
            case (fmt)
                rv64d_pkg::FMT_R:
                begin
                    res.rd  = rd;
                    res.rs1 = rs1;
                    res.rs2 = rs2;
                end
                rv64d_pkg::FMT_I:
                begin
                    res.rd  = rd;
                    res.rs1 = rs1;
                    res.imm = {20'd0, imm_i};
                end
                rv64d_pkg::FMT_S:
                begin
                    res.rs1 = rs1;
                    res.rs2 = rs2;
                    res.imm = {20'd0, word[31:25], word[11:7]};
                end
                rv64d_pkg::FMT_B:
                begin
                    res.rs1 = rs1;
                    res.rs2 = rs2;
                    res.imm = {19'd0, word[31], word[7], word[30:25], word[11:8], 1'b0};
                end
                rv64d_pkg::FMT_U:
                begin
                    res.rd  = rd;
                    res.imm = {word[31:12], 12'd0};
                end
                rv64d_pkg::FMT_J:
                begin
                    res.rd  = rd;
                    res.imm = {11'd0, word[31], word[19:12], word[20], word[30:21], 1'b0};
                end
                default:
                begin
                    res.rd = 5'd0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/rv64i_instruction_decoder_unit.sv */
// Top level of the RV64I instruction decoder: input register, decode, result register.
// Depends on rv64d_pkg, rv64d_instr_if, rv64d_decoded_if and rv64d_decode.
//
// Usage:
//   instr   - sink channel; one 32-bit instruction word per transaction.
//   decoded - source channel; operation code, format, rd/rs1/rs2 and the
//             raw (not sign extended) immediate for that word.
//   Every accepted word yields exactly one decoded transaction, in order.
//   A word accepted on instr is offered on decoded from the result register
//   (two register stages: instruction register, result register).
//   Throughput: one transaction per cycle while decoded.ready is high; the decode
//   between the two registers is a single shallow pass of bit selection and matching.
//   Stall: each stage advances when the stage after it is empty or being
//   drained, so instr.ready drops only when both stages hold data and
//   decoded.ready is low. A stalled result holds its payload.
//   Reset: rst_n clears both valid flags; no transaction is in flight and
//   instr.ready is high once reset is released.
`default_nettype none

module rv64i_instruction_decoder_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    rv64d_instr_if.sink         instr,
    rv64d_decoded_if.source     decoded
);

    logic               in_valid_reg;
    logic [31:0]        word_reg;
    logic               out_valid_reg;
    rv64d_pkg::result_t res_reg;
    rv64d_pkg::result_t res_next;
    logic               res_ready;

    // Stage handshakes
    assign res_ready   = !out_valid_reg || decoded.ready;
    assign instr.ready = !in_valid_reg || res_ready;

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (instr.ready)
                in_valid_reg <= instr.valid;
            if (res_ready)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (instr.valid && instr.ready)
            word_reg <= instr.instruction_word;
        if (in_valid_reg && res_ready)
            res_reg <= res_next;
    end

    rv64d_decode u_decode (
        .word (word_reg),
        .res  (res_next)
    );

    // Drive result channel
    assign decoded.valid          = out_valid_reg;
    assign decoded.operation_code = res_reg.op;
    assign decoded.format_kind    = res_reg.fmt;
    assign decoded.dest_reg       = res_reg.rd;
    assign decoded.src1_reg       = res_reg.rs1;
    assign decoded.src2_reg       = res_reg.rs2;
    assign decoded.immediate_bits = res_reg.imm;

endmodule

`default_nettype wire

/* sv/rv64d_checker.sv */
// Port-level checks for the RV64I decoder top level, plus the bind that attaches them.
// Depends on rv64d_pkg and rv64i_instruction_decoder_unit.
`default_nettype none

module rv64d_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        ready,
    input wire logic [5:0]  operation_code,
    input wire logic [2:0]  format_kind,
    input wire logic [4:0]  dest_reg,
    input wire logic [4:0]  src1_reg,
    input wire logic [4:0]  src2_reg,
    input wire logic [31:0] immediate_bits
);

    // Hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(operation_code) && $stable(immediate_bits))
        else $error("stalled decoded transaction changed");

    // Invalid words carry all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && operation_code == rv64d_pkg::OP_INVALID |->
            format_kind == rv64d_pkg::FMT_R && dest_reg == 5'd0 && src1_reg == 5'd0 &&
            src2_reg == 5'd0 && immediate_bits == 32'd0)
        else $error("invalid operation with nonzero fields");

    // R format has no immediate
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && format_kind == rv64d_pkg::FMT_R |-> immediate_bits == 32'd0)
        else $error("R format with immediate");

    // rs2 only for R, S and B; rd never for S and B
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && src2_reg != 5'd0 |->
            (format_kind == rv64d_pkg::FMT_R || format_kind == rv64d_pkg::FMT_S ||
             format_kind == rv64d_pkg::FMT_B))
        else $error("rs2 present in format without it");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid && (format_kind == rv64d_pkg::FMT_S || format_kind == rv64d_pkg::FMT_B) |->
            dest_reg == 5'd0)
        else $error("rd present in S or B format");

endmodule

bind rv64i_instruction_decoder_unit rv64d_checker u_rv64d_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (decoded.valid),
    .ready          (decoded.ready),
    .operation_code (decoded.operation_code),
    .format_kind    (decoded.format_kind),
    .dest_reg       (decoded.dest_reg),
    .src1_reg       (decoded.src1_reg),
    .src2_reg       (decoded.src2_reg),
    .immediate_bits (decoded.immediate_bits)
);

`default_nettype wire

/* bench/rv64i_instruction_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench for rv64i_instruction_decoder_unit: directed and random instruction words.
// Each result is checked against a decoder model in this file under random idling and output stalls.
// Depends on rv64d_pkg, rv64d_instr_if, rv64d_decoded_if and the decoder RTL.

module rv64i_instruction_decoder_unit_tb;
    import rv64d_pkg::*;

    localparam int CLK_HALF      = 1;
    localparam int RESET_CYCLES  = 7;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 40;
    localparam int PHASE_WORDS   = 105;

    // funct3 codes not named in the package
    localparam logic [2:0] F3_JALR     = 3'd0;
    localparam logic [2:0] F3_BEQ      = 3'd0;
    localparam logic [2:0] F3_BNE      = 3'd1;
    localparam logic [2:0] F3_BR_RSVD  = 3'd3;
    localparam logic [2:0] F3_BLT      = 3'd4;
    localparam logic [2:0] F3_BGE      = 3'd5;
    localparam logic [2:0] F3_BLTU     = 3'd6;
    localparam logic [2:0] F3_BGEU     = 3'd7;
    localparam logic [2:0] F3_BYTE     = 3'd0;
    localparam logic [2:0] F3_HALF     = 3'd1;
    localparam logic [2:0] F3_WORD     = 3'd2;
    localparam logic [2:0] F3_DOUBLE   = 3'd3;
    localparam logic [2:0] F3_BYTE_U   = 3'd4;
    localparam logic [2:0] F3_HALF_U   = 3'd5;
    localparam logic [2:0] F3_WORD_U   = 3'd6;
    localparam logic [2:0] F3_LD_RSVD  = 3'd7;
    localparam logic [2:0] F3_SLT      = 3'd2;
    localparam logic [2:0] F3_SLTU     = 3'd3;
    localparam logic [2:0] F3_XOR      = 3'd4;
    localparam logic [2:0] F3_OR       = 3'd6;
    localparam logic [2:0] F3_AND      = 3'd7;
    localparam logic [2:0] F3_FENCE    = 3'd0;
    localparam logic [2:0] F3_FENCE_I  = 3'd1;
    localparam logic [2:0] F3_PRIV     = 3'd0;
    localparam logic [2:0] F3_CSRRW    = 3'd1;

    logic clk;
    logic rst_n;

    rv64d_instr_if   instr_ch ();
    rv64d_decoded_if decoded_ch ();

    rv64i_instruction_decoder_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .instr   (instr_ch),
        .decoded (decoded_ch)
    );

    result_t decoded_due [$];
    int      fail_count;
    int      cycle_count;
    int      send_idle_pct;
    int      stall_pct;
    int      hold_requests;
    int      hold_served;
    int      hold_left;

    // Decode one word the way the decoder should
    function automatic result_t decode_word(input logic [31:0] w);
        result_t    r;
        op_t        op;
        fmt_t       fmt;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [5:0] f6;

        f3  = w[14:12];
        f7  = w[31:25];
        f6  = w[31:26];
        op  = OP_INVALID;
        fmt = FMT_R;
        case (w[6:0])
            OPC_LUI:   begin op = OP_LUI;   fmt = FMT_U; end
            OPC_AUIPC: begin op = OP_AUIPC; fmt = FMT_U; end
            OPC_JAL:   begin op = OP_JAL;   fmt = FMT_J; end
            OPC_JALR:
            begin
                fmt = FMT_I;
                op  = (f3 == F3_JALR) ? OP_JALR : OP_INVALID;
            end
            OPC_BRANCH:
            begin
                fmt = FMT_B;
                case (f3)
                    F3_BEQ:  op = OP_BEQ;
                    F3_BNE:  op = OP_BNE;
                    F3_BLT:  op = OP_BLT;
                    F3_BGE:  op = OP_BGE;
                    F3_BLTU: op = OP_BLTU;
                    F3_BGEU: op = OP_BGEU;
                    default: op = OP_INVALID;
                endcase
            end
            OPC_LOAD:
            begin
                fmt = FMT_I;
                case (f3)
                    F3_BYTE:   op = OP_LB;
                    F3_HALF:   op = OP_LH;
                    F3_WORD:   op = OP_LW;
                    F3_DOUBLE: op = OP_LD;
                    F3_BYTE_U: op = OP_LBU;
                    F3_HALF_U: op = OP_LHU;
                    F3_WORD_U: op = OP_LWU;
                    default:   op = OP_INVALID;
                endcase
            end
            OPC_STORE:
            begin
                fmt = FMT_S;
                case (f3)
                    F3_BYTE:   op = OP_SB;
                    F3_HALF:   op = OP_SH;
                    F3_WORD:   op = OP_SW;
                    F3_DOUBLE: op = OP_SD;
                    default:   op = OP_INVALID;
                endcase
            end
            OPC_OP_IMM:
            begin
                fmt = FMT_I;
                case (f3)
                    F3_ADD:  op = OP_ADDI;
                    F3_SLL:  op = (f6 == F6_BASE) ? OP_SLLI : OP_INVALID;
                    F3_SLT:  op = OP_SLTI;
                    F3_SLTU: op = OP_SLTIU;
                    F3_XOR:  op = OP_XORI;
                    F3_SR:   op = (f6 == F6_BASE) ? OP_SRLI :
                                  (f6 == F6_ALT)  ? OP_SRAI : OP_INVALID;
                    F3_OR:   op = OP_ORI;
                    default: op = OP_ANDI;
                endcase
            end
            OPC_OP_IMM32:
            begin
                fmt = FMT_I;
                case (f3)
                    F3_ADD:  op = OP_ADDIW;
                    F3_SLL:  op = (f7 == F7_BASE) ? OP_SLLIW : OP_INVALID;
                    F3_SR:   op = (f7 == F7_BASE) ? OP_SRLIW :
                                  (f7 == F7_ALT)  ? OP_SRAIW : OP_INVALID;
                    default: op = OP_INVALID;
                endcase
            end
            OPC_OP:
            begin
                fmt = FMT_R;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  op = OP_ADD;
                        F3_SLL:  op = OP_SLL;
                        F3_SLT:  op = OP_SLT;
                        F3_SLTU: op = OP_SLTU;
                        F3_XOR:  op = OP_XOR;
                        F3_SR:   op = OP_SRL;
                        F3_OR:   op = OP_OR;
                        default: op = OP_AND;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    op = OP_SUB;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    op = OP_SRA;
            end
            OPC_OP32:
            begin
                fmt = FMT_R;
                if (f7 == F7_BASE && f3 == F3_ADD)
                    op = OP_ADDW;
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    op = OP_SUBW;
                else if (f7 == F7_BASE && f3 == F3_SLL)
                    op = OP_SLLW;
                else if (f7 == F7_BASE && f3 == F3_SR)
                    op = OP_SRLW;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    op = OP_SRAW;
            end
            OPC_MISC_MEM:
            begin
                fmt = FMT_I;
                op  = (f3 == F3_FENCE) ? OP_FENCE : OP_INVALID;
            end
            OPC_SYSTEM:
            begin
                fmt = FMT_I;
                if (w[11:7] == 5'd0 && w[19:15] == 5'd0 && f3 == F3_PRIV)
                begin
                    case (w[31:20])
                        IMM_ECALL:  op = OP_ECALL;
                        IMM_EBREAK: op = OP_EBREAK;
                        IMM_SRET:   op = OP_SRET;
                        IMM_MRET:   op = OP_MRET;
                        default:    op = OP_INVALID;
                    endcase
                end
            end
            default: op = OP_INVALID;
        endcase

        // Pick out register fields and assemble the immediate for the format
        r = '0;
        if (op != OP_INVALID)
        begin
            r.op  = op;
            r.fmt = fmt;
            case (fmt)
                FMT_R:
                begin
                    r.rd  = w[11:7];
                    r.rs1 = w[19:15];
                    r.rs2 = w[24:20];
                end
                FMT_I:
                begin
                    r.rd  = w[11:7];
                    r.rs1 = w[19:15];
                    r.imm = {20'd0, w[31:20]};
                end
                FMT_S:
                begin
                    r.rs1 = w[19:15];
                    r.rs2 = w[24:20];
                    r.imm = {20'd0, w[31:25], w[11:7]};
                end
                FMT_B:
                begin
                    r.rs1 = w[19:15];
                    r.rs2 = w[24:20];
                    r.imm = {19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0};
                end
                FMT_U:
                begin
                    r.rd  = w[11:7];
                    r.imm = {w[31:12], 12'd0};
                end
                default:
                begin
                    r.rd  = w[11:7];
                    r.imm = {11'd0, w[31], w[19:12], w[20], w[30:21], 1'b0};
                end
            endcase
        end
        return r;
    endfunction

    // Render the fields of one decoded transaction for a report
    function automatic string result_text(input result_t r);
        return $sformatf("op=%0d fmt=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                         r.op, r.fmt, r.rd, r.rs1, r.rs2, r.imm);
    endfunction

    // Build a well-formed word for one operation with random operand bits
    function automatic logic [31:0] build_word(input op_t op);
        logic [31:0] w;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [11:0] sys_imm;

        w       = $urandom();
        opc     = w[6:0];
        f3      = w[14:12];
        f7      = w[31:25];
        sys_imm = w[31:20];
        case (op)
            OP_LUI:    opc = OPC_LUI;
            OP_AUIPC:  opc = OPC_AUIPC;
            OP_JAL:    opc = OPC_JAL;
            OP_JALR:   {opc, f3} = {OPC_JALR, F3_JALR};
            OP_BEQ:    {opc, f3} = {OPC_BRANCH, F3_BEQ};
            OP_BNE:    {opc, f3} = {OPC_BRANCH, F3_BNE};
            OP_BLT:    {opc, f3} = {OPC_BRANCH, F3_BLT};
            OP_BGE:    {opc, f3} = {OPC_BRANCH, F3_BGE};
            OP_BLTU:   {opc, f3} = {OPC_BRANCH, F3_BLTU};
            OP_BGEU:   {opc, f3} = {OPC_BRANCH, F3_BGEU};
            OP_LB:     {opc, f3} = {OPC_LOAD, F3_BYTE};
            OP_LH:     {opc, f3} = {OPC_LOAD, F3_HALF};
            OP_LW:     {opc, f3} = {OPC_LOAD, F3_WORD};
            OP_LD:     {opc, f3} = {OPC_LOAD, F3_DOUBLE};
            OP_LBU:    {opc, f3} = {OPC_LOAD, F3_BYTE_U};
            OP_LHU:    {opc, f3} = {OPC_LOAD, F3_HALF_U};
            OP_LWU:    {opc, f3} = {OPC_LOAD, F3_WORD_U};
            OP_SB:     {opc, f3} = {OPC_STORE, F3_BYTE};
            OP_SH:     {opc, f3} = {OPC_STORE, F3_HALF};
            OP_SW:     {opc, f3} = {OPC_STORE, F3_WORD};
            OP_SD:     {opc, f3} = {OPC_STORE, F3_DOUBLE};
            OP_ADDI:   {opc, f3} = {OPC_OP_IMM, F3_ADD};
            OP_SLTI:   {opc, f3} = {OPC_OP_IMM, F3_SLT};
            OP_SLTIU:  {opc, f3} = {OPC_OP_IMM, F3_SLTU};
            OP_XORI:   {opc, f3} = {OPC_OP_IMM, F3_XOR};
            OP_ORI:    {opc, f3} = {OPC_OP_IMM, F3_OR};
            OP_ANDI:   {opc, f3} = {OPC_OP_IMM, F3_AND};
            OP_SLLI:   {opc, f3, f7} = {OPC_OP_IMM, F3_SLL, F6_BASE, w[25]};
            OP_SRLI:   {opc, f3, f7} = {OPC_OP_IMM, F3_SR, F6_BASE, w[25]};
            OP_SRAI:   {opc, f3, f7} = {OPC_OP_IMM, F3_SR, F6_ALT, w[25]};
            OP_ADDIW:  {opc, f3} = {OPC_OP_IMM32, F3_ADD};
            OP_SLLIW:  {opc, f3, f7} = {OPC_OP_IMM32, F3_SLL, F7_BASE};
            OP_SRLIW:  {opc, f3, f7} = {OPC_OP_IMM32, F3_SR, F7_BASE};
            OP_SRAIW:  {opc, f3, f7} = {OPC_OP_IMM32, F3_SR, F7_ALT};
            OP_ADD:    {opc, f3, f7} = {OPC_OP, F3_ADD, F7_BASE};
            OP_SUB:    {opc, f3, f7} = {OPC_OP, F3_ADD, F7_ALT};
            OP_SLL:    {opc, f3, f7} = {OPC_OP, F3_SLL, F7_BASE};
            OP_SLT:    {opc, f3, f7} = {OPC_OP, F3_SLT, F7_BASE};
            OP_SLTU:   {opc, f3, f7} = {OPC_OP, F3_SLTU, F7_BASE};
            OP_XOR:    {opc, f3, f7} = {OPC_OP, F3_XOR, F7_BASE};
            OP_SRL:    {opc, f3, f7} = {OPC_OP, F3_SR, F7_BASE};
            OP_SRA:    {opc, f3, f7} = {OPC_OP, F3_SR, F7_ALT};
            OP_OR:     {opc, f3, f7} = {OPC_OP, F3_OR, F7_BASE};
            OP_AND:    {opc, f3, f7} = {OPC_OP, F3_AND, F7_BASE};
            OP_ADDW:   {opc, f3, f7} = {OPC_OP32, F3_ADD, F7_BASE};
            OP_SUBW:   {opc, f3, f7} = {OPC_OP32, F3_ADD, F7_ALT};
            OP_SLLW:   {opc, f3, f7} = {OPC_OP32, F3_SLL, F7_BASE};
            OP_SRLW:   {opc, f3, f7} = {OPC_OP32, F3_SR, F7_BASE};
            OP_SRAW:   {opc, f3, f7} = {OPC_OP32, F3_SR, F7_ALT};
            OP_FENCE:  {opc, f3} = {OPC_MISC_MEM, F3_FENCE};
            OP_ECALL:  {opc, sys_imm} = {OPC_SYSTEM, IMM_ECALL};
            OP_EBREAK: {opc, sys_imm} = {OPC_SYSTEM, IMM_EBREAK};
            OP_SRET:   {opc, sys_imm} = {OPC_SYSTEM, IMM_SRET};
            OP_MRET:   {opc, sys_imm} = {OPC_SYSTEM, IMM_MRET};
            default:   opc = w[6:0];
        endcase
        w[6:0]   = opc;
        w[14:12] = f3;
        w[31:25] = f7;
        // System words need zero rd, rs1 and funct3
        if (opc == OPC_SYSTEM)
            w = {sys_imm, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM};
        return w;
    endfunction

    // Mostly well-formed words, some with one bit broken, some pure noise
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int unsigned roll;
        int unsigned bit_pos;

        roll = $urandom_range(0, 99);
        w    = build_word(op_t'($urandom_range(OP_LUI, OP_MRET)));
        if (roll >= 90)
            w = $urandom();
        else if (roll >= 75)
        begin
            bit_pos    = $urandom_range(0, 31);
            w[bit_pos] = ~w[bit_pos];
        end
        return w;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAIL rv64i_instruction_decoder_unit");
            $finish;
        end
    end

    // Drive ready: long hold-offs on request, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            decoded_ch.ready <= 1'b0;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            decoded_ch.ready <= 1'b0;
        end
        else
            decoded_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check each decoded transaction against the oldest outstanding word
    always @(posedge clk)
    begin
        result_t got;
        result_t want;

        if (rst_n && decoded_ch.valid && decoded_ch.ready)
        begin
            got = {decoded_ch.operation_code, decoded_ch.format_kind, decoded_ch.dest_reg,
                   decoded_ch.src1_reg, decoded_ch.src2_reg, decoded_ch.immediate_bits};
            if (decoded_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: decoded transaction with no word outstanding: %h",
                             $time, got);
            end
            else
            begin
                want = decoded_due.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: mismatch expected %s, actual %s",
                                 $time, result_text(want), result_text(got));
                end
            end
        end
    end

    // Offer one word, optionally after idle cycles, and hold it until accepted
    task automatic send_word(input logic [31:0] w);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            instr_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        instr_ch.valid            <= 1'b1;
        instr_ch.instruction_word <= w;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        decoded_due.push_back(decode_word(w));
    endtask

    // Field extremes and special cases of the decode
    task automatic test_directed_words();
        logic [31:0] words [$];

        send_idle_pct = 0;
        stall_pct     = 0;
        words = '{
            32'h0000_0000,
            32'hFFFF_FFFF,
            {20'hFFFFF, 5'd31, OPC_LUI},
            {25'h1FF_FFFF, OPC_JAL},
            {12'hFFF, 5'd31, F3_JALR, 5'd31, OPC_JALR},
            {12'h123, 5'd2, ~F3_JALR, 5'd3, OPC_JALR},
            {7'h7F, 5'd31, 5'd31, F3_BGEU, 5'd31, OPC_BRANCH},
            {7'h00, 5'd1, 5'd2, F3_BR_RSVD, 5'd3, OPC_BRANCH},
            {12'hFFF, 5'd31, F3_WORD_U, 5'd31, OPC_LOAD},
            {12'h0F0, 5'd1, F3_LD_RSVD, 5'd1, OPC_LOAD},
            {7'h7F, 5'd31, 5'd31, F3_DOUBLE, 5'd31, OPC_STORE},
            {F6_BASE, 6'h3F, 5'd31, F3_SLL, 5'd31, OPC_OP_IMM},
            {~F6_BASE, 6'h01, 5'd4, F3_SLL, 5'd5, OPC_OP_IMM},
            {F6_ALT, 6'h3F, 5'd31, F3_SR, 5'd31, OPC_OP_IMM},
            {~F6_ALT, 6'h02, 5'd6, F3_SR, 5'd7, OPC_OP_IMM},
            {F7_ALT, 5'd31, 5'd31, F3_SR, 5'd31, OPC_OP_IMM32},
            {F6_ALT, 1'b1, 5'd3, 5'd4, F3_SR, 5'd5, OPC_OP_IMM32},
            {F6_BASE, 1'b1, 5'd3, 5'd4, F3_SLL, 5'd5, OPC_OP_IMM32},
            {F6_BASE, 1'b1, 5'd2, 5'd3, F3_ADD, 5'd4, OPC_OP},
            {F7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP},
            {12'hFFF, 5'd31, F3_FENCE, 5'd31, OPC_MISC_MEM},
            {12'h000, 5'd0, F3_FENCE_I, 5'd0, OPC_MISC_MEM},
            {IMM_ECALL, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM},
            {IMM_EBREAK, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM},
            {IMM_SRET, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM},
            {IMM_MRET, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM},
            {IMM_MRET, 5'd0, F3_PRIV, 5'd1, OPC_SYSTEM},
            {12'h300, 5'd1, F3_CSRRW, 5'd2, OPC_SYSTEM}
        };
        foreach (words[i])
            send_word(words[i]);
    endtask

    // Random words under one idling setting
    task automatic test_random_traffic(input int idle_pct, input int stall_in_pct,
                                       input int count);
        send_idle_pct = idle_pct;
        stall_pct     = stall_in_pct;
        repeat (count)
            send_word(pick_word());
    endtask

    // Hold off the result side long enough for the pipeline to fill and stall
    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests <= hold_requests + 1;
        repeat (16)
            send_word(pick_word());
    endtask

    // Reset, run the tests in turn, drain and report
    initial
    begin
        rst_n                     = 1'b0;
        instr_ch.valid            = 1'b0;
        instr_ch.instruction_word = '0;
        decoded_ch.ready          = 1'b0;
        fail_count                = 0;
        cycle_count               = 0;
        send_idle_pct             = 0;
        stall_pct                 = 0;
        hold_requests             = 0;
        hold_served               = 0;
        hold_left                 = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_words();
        test_random_traffic(0, 0, PHASE_WORDS);
        test_random_traffic(69, 0, PHASE_WORDS);
        test_random_traffic(0, 69, PHASE_WORDS);
        test_backpressure_fill();
        test_random_traffic(32, 32, PHASE_WORDS);
        instr_ch.valid <= 1'b0;

        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && decoded_due.size() == 0)
            $display("PASS rv64i_instruction_decoder_unit");
        else
            $display("FAIL rv64i_instruction_decoder_unit");
        $finish;
    end

endmodule
